// ----- rtl/sks_pkg.sv -----
// Shared widths, codes and defaults for the sorted key set.
package sks_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int KEY_WIDTH_DEF = 64;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

endpackage

// ----- rtl/sks_if.sv -----
// Request and response channel interfaces of the sorted key set.
interface sks_req_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::OP_W-1:0]      op;
   logic [sks_pkg::KEY_W-1:0]     key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

interface sks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::STATUS_W-1:0]  status;
   logic [sks_pkg::POS_W-1:0]     position;
   logic [sks_pkg::COUNT_W-1:0]   count;

   modport source (output valid, output status, output position, output count,
                   input ready);
   modport sink   (input valid, input status, input position, input count,
                   output ready);
endinterface

// ----- rtl/sorted_key_set_core.sv -----
// Sorted key set: ordered key table with a sequenced search and shift engine.
//
//   channel   direction  payload                      handshake
//   req_chan  in         op, key                      valid / ready
//   rsp_chan  out        status, position, count      valid / ready
//
// One word is processed at a time; ready is high only while the engine idles.
// Each held key below the search key is read (S_READ) and compared (S_CMP); an
// insert or remove then moves each displaced entry by a read (S_SHIFT_RD) and a
// write (S_SHIFT_WR) before S_FINISH registers the response and ready returns.
// Reset clears the count and the control state; table contents need no clear.
// A stalled response holds in the output register while the next word runs.
module sorted_key_set_core #(
   parameter int DEPTH     = sks_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = sks_pkg::KEY_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   sks_req_if.sink    req_chan,
   sks_rsp_if.source  rsp_chan
);
   import sks_pkg::*;

   localparam int IDX_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_READ     = 7'b0000010,
      S_CMP      = 7'b0000100,
      S_DECIDE   = 7'b0001000,
      S_SHIFT_RD = 7'b0010000,
      S_SHIFT_WR = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         count_ff, count_in;
   logic [STATUS_W-1:0]      stat_ff, stat_in;
   logic [IDX_W-1:0]         where_ff, where_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]         rsp_position_ff, rsp_position_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH-1:0]     key_mem [DEPTH];
   logic [KEY_WIDTH-1:0]     rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0]     wr_data;

   logic [IDX_W-1:0]         idx_inc, idx_dec;
   logic                     rsp_free;
   logic                     req_fire;

   assign idx_inc  = idx_ff + IDX_W'(1);
   assign idx_dec  = idx_ff - IDX_W'(1);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.position = rsp_position_ff;
   assign rsp_chan.count    = rsp_count_ff;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      idx_in          = idx_ff;
      pos_in          = pos_ff;
      hit_in          = hit_ff;
      count_in        = count_ff;
      stat_in         = stat_ff;
      where_in        = where_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rd_addr         = idx_ff[ADDR_W-1:0];
      wr_en           = 1'b0;
      wr_addr         = idx_ff[ADDR_W-1:0];
      wr_data         = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.op;
               key_in   = req_chan.key[KEY_WIDTH-1:0];
               idx_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Running off the end means every held key is below the search key.
            if (idx_ff == count_ff) begin
               pos_in   = count_ff;
               hit_in   = 1'b0;
               state_in = S_DECIDE;
            end else begin
               rd_addr  = idx_ff[ADDR_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_data_ff >= key_ff) begin
               pos_in   = idx_ff;
               hit_in   = (rd_data_ff == key_ff);
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_inc;
               state_in = S_READ;
            end
         end
         S_DECIDE: begin
            stat_in  = ST_ABSENT;
            where_in = DEPTH_IDX;
            state_in = S_FINISH;
            case (op_ff)
               OP_INSERT: begin
                  if (hit_ff) begin
                     stat_in  = ST_DUPLICATE;
                     where_in = pos_ff;
                  end else if (count_ff >= DEPTH_IDX) begin
                     stat_in  = ST_FULL;
                  end else begin
                     stat_in  = ST_INSERTED;
                     where_in = pos_ff;
                     idx_in   = count_ff;
                     state_in = S_SHIFT_RD;
                  end
               end
               OP_LOOKUP: begin
                  if (hit_ff) begin
                     stat_in  = ST_FOUND;
                     where_in = pos_ff;
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff) begin
                     stat_in  = ST_REMOVED;
                     where_in = pos_ff;
                     idx_in   = pos_ff;
                     state_in = S_SHIFT_RD;
                  end
               end
               default: begin
                  stat_in = ST_ABSENT;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (op_ff == OP_INSERT) begin
               if (idx_ff == pos_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[ADDR_W-1:0];
                  wr_data  = key_ff;
                  count_in = count_ff + IDX_W'(1);
                  state_in = S_FINISH;
               end else begin
                  rd_addr  = idx_dec[ADDR_W-1:0];
                  state_in = S_SHIFT_WR;
               end
            end else begin
               if (idx_inc >= count_ff) begin
                  count_in = count_ff - IDX_W'(1);
                  state_in = S_FINISH;
               end else begin
                  rd_addr  = idx_inc[ADDR_W-1:0];
                  state_in = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[ADDR_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = (op_ff == OP_INSERT) ? idx_dec : idx_inc;
            state_in = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = stat_ff;
               rsp_position_in = POS_W'(where_ff);
               rsp_count_in    = COUNT_W'(count_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      key_ff          <= key_in;
      idx_ff          <= idx_in;
      pos_ff          <= pos_in;
      hit_ff          <= hit_in;
      stat_ff         <= stat_in;
      where_ff        <= where_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   // Key table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_IDX)
      else $error("held key count exceeds the table depth");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CMP) |-> idx_ff <= count_ff)
      else $error("search index ran past the held keys");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && stat_ff == ST_FULL) |-> count_ff == DEPTH_IDX)
      else $error("table full reported while space remains");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD && op_ff == OP_INSERT && idx_ff == pos_ff)
      |=> count_ff == $past(count_ff) + IDX_W'(1))
      else $error("count did not grow after an insert");

   a_remove_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && op_ff == OP_REMOVE && hit_ff)
      |-> (pos_ff < count_ff && count_ff != '0))
      else $error("remove hit outside the held keys");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for sorted_key_set_core: random key traffic, ordered-table predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sks_pkg::*;

   localparam int DEPTH      = DEPTH_DEF;
   localparam int KEY_WIDTH  = KEY_WIDTH_DEF;
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_WIDTH);
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int POOL_SIZE  = 24;
   localparam int RANDOM_WORDS = 1950;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
   localparam int STALL_LIMIT  = 3000;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
   } set_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } set_result_type;

   typedef enum {FILL_UP, DRAIN, MIXED} mix_type;

   logic clock;
   logic reset;

   sks_req_if req_chan();
   sks_rsp_if rsp_chan();

   sorted_key_set_core #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted table contents, ascending in 0..held_n-1.
   logic [KEY_W-1:0] held_keys [DEPTH];
   int               held_n = 0;

   set_word_type   queued_words [$];
   set_result_type due_results [$];
   logic [KEY_W-1:0] gen_live [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   set_word_type   next_word;
   set_result_type seen;
   set_result_type want;
   int  total_words;
   int  words_in = 0;
   int  words_out = 0;
   int  fail_count = 0;
   int  idle_cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_fired = 1'b0;
   bit  rsp_fired = 1'b0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  req_steady = 1'b0;
   bit  rsp_steady = 1'b0;
   int  phase_len;
   mix_type phase_kind;
   int  ins_w;
   int  rem_w;
   int  gen_r;
   logic [OP_W-1:0]  gen_op;
   logic [KEY_W-1:0] gen_key;

   function automatic set_result_type next_set_result(logic [OP_W-1:0] op,
                                                      logic [KEY_W-1:0] raw_key);
      logic [KEY_W-1:0] k;
      int             slot;
      bit             hit;
      set_result_type r;
      k = raw_key & KEY_MASK;
      slot = held_n;
      for (int i = held_n - 1; i >= 0; i--) begin
         if (held_keys[i] >= k) slot = i;
      end
      hit = (slot < held_n) && (held_keys[slot] == k);
      r.status = ST_ABSENT;
      r.position = POS_W'(DEPTH);
      case (op)
         OP_INSERT: begin
            if (hit) begin
               r.status = ST_DUPLICATE;
               r.position = POS_W'(slot);
            end else if (held_n >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = held_n; i > slot; i--) held_keys[i] = held_keys[i-1];
               held_keys[slot] = k;
               held_n++;
               r.status = ST_INSERTED;
               r.position = POS_W'(slot);
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               r.status = ST_FOUND;
               r.position = POS_W'(slot);
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               for (int i = slot; i + 1 < held_n; i++) held_keys[i] = held_keys[i+1];
               held_n--;
               r.status = ST_REMOVED;
               r.position = POS_W'(slot);
            end
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(held_n);
      return r;
   endfunction

   // Keys that sit close together or at the edges exercise the comparator hardest.
   function automatic logic [KEY_W-1:0] random_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 5))
         0: k = {$urandom, $urandom};
         1: k = KEY_W'($urandom_range(0, 15));
         2: k = ~KEY_W'($urandom_range(0, 15));
         3: k = 64'h8000_0000_0000_0000 ^ KEY_W'($urandom_range(0, 7));
         4: k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
         default: k = ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
      endcase
      return k;
   endfunction

   // Queues a word and tracks which keys the table should roughly hold, for key choice.
   function automatic void add_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
      set_word_type w;
      int idx;
      w.op = op;
      w.key = key;
      queued_words.push_back(w);
      idx = -1;
      foreach (gen_live[i]) begin
         if (gen_live[i] == (key & KEY_MASK)) idx = i;
      end
      if (op == OP_INSERT && idx < 0 && gen_live.size() < DEPTH) begin
         gen_live.push_back(key & KEY_MASK);
      end else if (op == OP_REMOVE && idx >= 0) begin
         gen_live.delete(idx);
      end
   endfunction

   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_INSERT;
      req_chan.key = '0;
      rsp_chan.ready = 1'b0;

      add_word(OP_LOOKUP, 64'd5);
      add_word(OP_REMOVE, 64'd5);
      add_word(OP_SPARE, {KEY_W{1'b1}});
      add_word(OP_INSERT, 64'd0);
      add_word(OP_INSERT, {KEY_W{1'b1}});
      add_word(OP_INSERT, 64'd0);
      add_word(OP_INSERT, 64'h8000_0000_0000_0000);
      for (int i = 1; i <= DEPTH - 3; i++) add_word(OP_INSERT, 64'h0101_0101_0101_0101 * i);
      add_word(OP_INSERT, 64'h1234);
      add_word(OP_INSERT, {KEY_W{1'b1}});
      add_word(OP_LOOKUP, {KEY_W{1'b1}});
      add_word(OP_REMOVE, 64'd0);
      add_word(OP_REMOVE, {KEY_W{1'b1}});

      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
      while (queued_words.size() < RANDOM_WORDS) begin
         phase_len = $urandom_range(60, 140);
         if (phase_len > RANDOM_WORDS - queued_words.size()) begin
            phase_len = RANDOM_WORDS - queued_words.size();
         end
         phase_kind = mix_type'($urandom_range(0, 2));
         ins_w = (phase_kind == FILL_UP) ? 60 : (phase_kind == DRAIN) ? 15 : 35;
         rem_w = (phase_kind == FILL_UP) ? 15 : (phase_kind == DRAIN) ? 60 : 30;
         repeat (6) key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < 4) begin
               gen_op = OP_W'($urandom_range(0, 3));
               gen_key = {$urandom, $urandom};
            end else begin
               gen_r = $urandom_range(0, 99);
               if (gen_r < ins_w) gen_op = OP_INSERT;
               else if (gen_r < ins_w + rem_w) gen_op = OP_REMOVE;
               else gen_op = OP_LOOKUP;
               gen_r = $urandom_range(0, 99);
               if (gen_live.size() > 0 && gen_r < ((gen_op == OP_INSERT) ? 15 : 60)) begin
                  gen_key = gen_live[$urandom_range(0, gen_live.size() - 1)];
               end else if (gen_r < 90) begin
                  gen_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
               end else begin
                  gen_key = random_key();
               end
            end
            add_word(gen_op, gen_key);
         end
      end
      total_words = queued_words.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_in < total_words || due_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Request driver: a word stays offered until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_fired) begin
         req_chan.valid <= 1'b1;
      end else if (req_gap > 0) begin
         req_chan.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (queued_words.size() > 0) begin
         next_word = queued_words.pop_front();
         req_chan.valid <= 1'b1;
         req_chan.op <= next_word.op;
         req_chan.key <= next_word.key;
         req_gap <= pick_gap(req_steady);
         if ($urandom_range(0, 49) == 0) req_steady <= !req_steady;
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Response back-pressure; a stall only counts down while a word is waiting.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            rsp_stall = pick_gap(rsp_steady);
            if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
         end
         if (hold_left > 0 || rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            if (rsp_stall > 0 && rsp_chan.valid) rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // One long hold-off on the response side so the core fills and blocks its input.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_out >= 300) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Monitor: check each response word against the oldest prediction, then predict.
   always @(posedge clock) begin
      req_fired <= !reset && req_chan.valid && req_chan.ready;
      rsp_fired <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         words_out <= words_out + 1;
         seen.status = rsp_chan.status;
         seen.position = rsp_chan.position;
         seen.count = rsp_chan.count;
         if (due_results.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected response word: status %0d position %0d count %0d",
                        seen.status, seen.position, seen.count);
            end
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (seen !== want) begin
               if (fail_count < 10) begin
                  $display({"mismatch at response %0d: expected status %0d position %0d",
                            " count %0d, got status %0d position %0d count %0d"},
                           words_out, want.status, want.position, want.count,
                           seen.status, seen.position, seen.count);
               end
               fail_count++;
            end
         end
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         due_results.push_back(next_set_result(req_chan.op, req_chan.key));
         words_in <= words_in + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- filelist.f -----
rtl/sks_pkg.sv
rtl/sks_if.sv
rtl/sorted_key_set_core.sv
verif/tb.sv
